FILE: src/khs_pkg.sv
// ----------------------------------------------------------------------------
// khs_pkg
// Shared types, widths and constants of the k-mer hash scan block.
// ----------------------------------------------------------------------------
package khs_pkg;

    localparam int KMER_LEN    = 8;
    localparam int TABLE_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int CFG_W       = 17;
    localparam int KEY_W       = 35;
    localparam int SYM_W       = 5;
    localparam int POS_W       = 20;
    localparam int SLOT_W      = 16;
    localparam int BIT_CNT_W   = $clog2(KEY_W);
    localparam int RUN_W       = $clog2(KMER_LEN + 1);

    localparam logic [POS_W-1:0] POS_MAX    = {POS_W{1'b1}};
    localparam logic [SYM_W-1:0] SYM_AMBIG  = 5'd20;
    localparam logic [SYM_W-1:0] RADIX      = 5'd20;

    // Commands.
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_SYMBOL = 2'd1;
    localparam logic [1:0] CMD_NEWSEQ = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_STORED  = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_HIT     = 2'd2;

    // Power of 20, evaluated on constants at elaboration.
    function automatic logic [KEY_W-1:0] pow20(input int n);
        logic [KEY_W-1:0] v;
        v = KEY_W'(1);
        for (int i = 0; i < n; i++) begin
            v = KEY_W'(v * KEY_W'(20));
        end
        return v;
    endfunction

    localparam logic [KEY_W-1:0] TOP_WEIGHT = pow20(KMER_LEN - 1);

    typedef struct packed {
        logic [15:0] end_offset;
        logic [19:0] function_id;
        logic [19:0] group_id;
        logic [15:0] weight;
    } khs_payload_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        khs_payload_t     payload;
    } khs_slot_t;

    typedef struct packed {
        logic             is_insert;
        logic [KEY_W-1:0] key;
        khs_payload_t     payload;
        logic [POS_W-1:0] position;
    } khs_job_t;

endpackage

FILE: src/kmer_hash_scan_core.sv
// ----------------------------------------------------------------------------
// kmer_hash_scan_core
// Signature k-mer hash table with a rolling window lookup over symbols.
// ----------------------------------------------------------------------------
// Flow: an insert leaves the front through F_PUSH; a valid symbol goes through
// F_SHIFT and, once the window is full, F_PUSH; other items end in F_IDLE. The
// back takes one table job at a time in B_IDLE, answers a refused insert there,
// reduces the key mod size one bit per cycle and probes each slot in B_RD and B_CHK.
// Reset: synchronous, active low; afterwards a clearing pass writes all
// 65536 slots, one per cycle, and no item is accepted until it ends.
module kmer_hash_scan_core
    import khs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_command,
    input  logic [SYM_W-1:0]  s_symbol,
    input  logic [KEY_W-1:0]  s_key,
    input  logic [15:0]       s_end_offset,
    input  logic [19:0]       s_function_id,
    input  logic [19:0]       s_group_id,
    input  logic [15:0]       s_weight,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic [SLOT_W-1:0] m_slot,
    output logic [POS_W-1:0]  m_position,
    output logic [KEY_W-1:0]  m_hit_key,
    output logic [15:0]       m_hit_end_offset,
    output logic [19:0]       m_hit_function,
    output logic [19:0]       m_hit_group,
    output logic [15:0]       m_hit_weight
);

    logic [CFG_W-1:0] table_size_reg;
    logic [CNT_W-1:0] size;
    khs_payload_t     s_payload;
    khs_payload_t     m_payload;
    khs_job_t         f_job, b_job;
    logic             f_valid, f_ready, b_valid, b_ready;
    logic             clearing;
    logic             front_busy;
    logic             front_hold;

    // The size register is taken only when no item is in flight.
    assign cfg_ready  = !front_busy && !b_valid && b_ready;
    assign front_hold = clearing || cfg_valid;

    // Table size register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg <= CFG_W'(65536);
        end else if (cfg_valid && cfg_ready) begin
            table_size_reg <= cfg_data;
        end
    end

    // Clamp the table size to the usable range.
    always_comb begin
        if (table_size_reg < CFG_W'(2)) begin
            size = CNT_W'(2);
        end else if (table_size_reg > CFG_W'(TABLE_DEPTH)) begin
            size = CNT_W'(TABLE_DEPTH);
        end else begin
            size = CNT_W'(table_size_reg);
        end
    end

    assign s_payload.end_offset  = s_end_offset;
    assign s_payload.function_id = s_function_id;
    assign s_payload.group_id    = s_group_id;
    assign s_payload.weight      = s_weight;

    assign m_hit_end_offset = m_payload.end_offset;
    assign m_hit_function   = m_payload.function_id;
    assign m_hit_group      = m_payload.group_id;
    assign m_hit_weight     = m_payload.weight;

    khs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .hold      (front_hold),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_symbol  (s_symbol),
        .s_key     (s_key),
        .s_payload (s_payload),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job),
        .busy      (front_busy)
    );

    khs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_job    (f_job),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_job   (b_job)
    );

    khs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .size       (size),
        .job_valid  (b_valid),
        .job_ready  (b_ready),
        .job        (b_job),
        .clearing   (clearing),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_slot     (m_slot),
        .m_position (m_position),
        .m_hit_key  (m_hit_key),
        .m_payload  (m_payload)
    );

endmodule

FILE: src/khs_ram.sv
// ----------------------------------------------------------------------------
// khs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module khs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/khs_queue.sv
// ----------------------------------------------------------------------------
// khs_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module khs_queue
    import khs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  khs_job_t in_job,
    output logic     out_valid,
    input  logic     out_ready,
    output khs_job_t out_job
);

    khs_job_t   buf_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_job   = buf_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Storage, written at the write pointer.
    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= in_job;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

FILE: src/khs_front.sv
// ----------------------------------------------------------------------------
// khs_front
// Accepts items, keeps the rolling k-mer window and issues table jobs.
// ----------------------------------------------------------------------------
module khs_front
    import khs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             hold,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_command,
    input  logic [SYM_W-1:0] s_symbol,
    input  logic [KEY_W-1:0] s_key,
    input  khs_payload_t     s_payload,
    output logic             job_valid,
    input  logic             job_ready,
    output khs_job_t         job,
    output logic             busy
);

    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_SHIFT = 2'd1;
    localparam logic [1:0] F_PUSH  = 2'd2;

    logic [1:0]       state_reg;
    logic [SYM_W-1:0] dig_reg [KMER_LEN];
    logic [KEY_W-1:0] win_reg;
    logic [KEY_W-1:0] reduced_reg;
    logic [SYM_W-1:0] sym_reg;
    logic [RUN_W-1:0] run_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] cur_reg;
    khs_job_t         job_reg;
    logic             accept;
    logic [KEY_W-1:0] top_part;
    logic [KEY_W-1:0] win_next;
    logic [RUN_W-1:0] run_next;
    logic [POS_W-1:0] start_pos;

    assign s_ready   = (state_reg == F_IDLE) && !hold;
    assign accept    = s_valid && s_ready;
    assign job_valid = (state_reg == F_PUSH);
    assign job       = job_reg;
    assign busy      = (state_reg != F_IDLE);

    // Weight of the digit that leaves the window, and the shifted key.
    assign top_part = KEY_W'(dig_reg[KMER_LEN-1] * TOP_WEIGHT);
    assign win_next = KEY_W'({reduced_reg, 4'b0} + {reduced_reg, 2'b0})
                      + KEY_W'(sym_reg);
    assign run_next = (run_reg < RUN_W'(KMER_LEN)) ? run_reg + RUN_W'(1) : run_reg;
    assign start_pos = (cur_reg >= POS_MAX) ? POS_MAX
                                            : cur_reg - POS_W'(KMER_LEN - 1);

    // Window state, position and job sequencing.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            win_reg   <= '0;
            run_reg   <= '0;
            pos_reg   <= '0;
            for (int i = 0; i < KMER_LEN; i++) begin
                dig_reg[i] <= '0;
            end
        end else begin
            unique case (state_reg)
                F_IDLE: begin
                    if (accept) begin
                        case (s_command)
                            CMD_INSERT: begin
                                job_reg.is_insert <= 1'b1;
                                job_reg.key       <= s_key;
                                job_reg.payload   <= s_payload;
                                job_reg.position  <= '0;
                                state_reg         <= F_PUSH;
                            end
                            CMD_SYMBOL: begin
                                cur_reg <= pos_reg;
                                if (pos_reg < POS_MAX) begin
                                    pos_reg <= pos_reg + POS_W'(1);
                                end
                                if (s_symbol >= SYM_AMBIG) begin
                                    win_reg <= '0;
                                    run_reg <= '0;
                                    for (int i = 0; i < KMER_LEN; i++) begin
                                        dig_reg[i] <= '0;
                                    end
                                end else begin
                                    reduced_reg <= win_reg - top_part;
                                    sym_reg     <= s_symbol;
                                    state_reg   <= F_SHIFT;
                                end
                            end
                            CMD_NEWSEQ: begin
                                win_reg <= '0;
                                run_reg <= '0;
                                pos_reg <= '0;
                                for (int i = 0; i < KMER_LEN; i++) begin
                                    dig_reg[i] <= '0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                F_SHIFT: begin
                    win_reg    <= win_next;
                    run_reg    <= run_next;
                    dig_reg[0] <= sym_reg;
                    for (int i = 1; i < KMER_LEN; i++) begin
                        dig_reg[i] <= dig_reg[i-1];
                    end
                    job_reg.is_insert <= 1'b0;
                    job_reg.key       <= win_next;
                    job_reg.payload   <= '0;
                    job_reg.position  <= start_pos;
                    state_reg <= (run_next == RUN_W'(KMER_LEN)) ? F_PUSH : F_IDLE;
                end
                F_PUSH: begin
                    if (job_ready) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: src/khs_back.sv
// ----------------------------------------------------------------------------
// khs_back
// Clears the table after reset, then runs insert and lookup jobs by
// linear probing, and holds the result item register.
// ----------------------------------------------------------------------------
module khs_back
    import khs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [CNT_W-1:0]  size,
    input  logic              job_valid,
    output logic              job_ready,
    input  khs_job_t          job,
    output logic              clearing,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic [SLOT_W-1:0] m_slot,
    output logic [POS_W-1:0]  m_position,
    output logic [KEY_W-1:0]  m_hit_key,
    output khs_payload_t      m_payload
);

    localparam logic [2:0] B_CLEAR = 3'd0;
    localparam logic [2:0] B_IDLE  = 3'd1;
    localparam logic [2:0] B_MOD   = 3'd2;
    localparam logic [2:0] B_RD    = 3'd3;
    localparam logic [2:0] B_CHK   = 3'd4;

    logic [2:0]           state_reg;
    logic [ADDR_W-1:0]    idx_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [BIT_CNT_W-1:0] bit_reg;
    logic [CNT_W-1:0]     entries_reg;
    khs_job_t             job_reg;
    logic                 m_valid_reg;
    logic [1:0]           status_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [POS_W-1:0]     position_reg;
    logic [KEY_W-1:0]     hit_key_reg;
    khs_payload_t         payload_reg;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    khs_slot_t            ram_wdata;
    khs_slot_t            ram_rdata;
    logic [CNT_W-1:0]     rem_sh;
    logic [CNT_W-1:0]     rem_next;
    logic [CNT_W-1:0]     idx_inc;
    logic [ADDR_W-1:0]    idx_adv;
    logic [CNT_W-1:0]     cnt_inc;
    logic                 full;

    khs_ram #(
        .WIDTH ($bits(khs_slot_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign clearing   = (state_reg == B_CLEAR);
    assign job_ready  = (state_reg == B_IDLE) && !m_valid_reg;
    assign m_valid    = m_valid_reg;
    assign m_status   = status_reg;
    assign m_slot     = slot_reg;
    assign m_position = position_reg;
    assign m_hit_key  = hit_key_reg;
    assign m_payload  = payload_reg;

    // One restoring step of key mod size.
    assign rem_sh   = {rem_reg[CNT_W-2:0], job_reg.key[bit_reg]};
    assign rem_next = (rem_sh >= size) ? rem_sh - size : rem_sh;

    // Next probe slot with wrap at size, and probe count.
    assign idx_inc = {1'b0, idx_reg} + CNT_W'(1);
    assign idx_adv = (idx_inc == size) ? '0 : idx_inc[ADDR_W-1:0];
    assign cnt_inc = cnt_reg + CNT_W'(1);
    assign full    = ({1'b0, entries_reg} + (CNT_W+1)'(1)) >= (CNT_W+1)'(size >> 1);

    // Table writes: the clearing sweep, or an insert into an empty slot.
    always_comb begin
        ram_waddr = idx_reg;
        ram_wdata = '0;
        ram_we    = 1'b0;
        if (state_reg == B_CLEAR) begin
            ram_we = 1'b1;
        end else if (state_reg == B_CHK && job_reg.is_insert && !ram_rdata.valid) begin
            ram_we            = 1'b1;
            ram_wdata.valid   = 1'b1;
            ram_wdata.key     = job_reg.key;
            ram_wdata.payload = job_reg.payload;
        end
    end

    // Job sequencer and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_CLEAR;
            idx_reg     <= '0;
            entries_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_CLEAR: begin
                    idx_reg <= idx_reg + ADDR_W'(1);
                    if (idx_reg == ADDR_W'(TABLE_DEPTH - 1)) begin
                        state_reg <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (job_valid && job_ready) begin
                        job_reg <= job;
                        rem_reg <= '0;
                        bit_reg <= BIT_CNT_W'(KEY_W - 1);
                        if (job.is_insert && full) begin
                            m_valid_reg  <= 1'b1;
                            status_reg   <= ST_REFUSED;
                            slot_reg     <= '0;
                            position_reg <= '0;
                            hit_key_reg  <= '0;
                            payload_reg  <= '0;
                        end else begin
                            state_reg <= B_MOD;
                        end
                    end
                end
                B_MOD: begin
                    rem_reg <= rem_next;
                    bit_reg <= bit_reg - BIT_CNT_W'(1);
                    if (bit_reg == '0) begin
                        idx_reg   <= rem_next[ADDR_W-1:0];
                        cnt_reg   <= '0;
                        state_reg <= B_RD;
                    end
                end
                B_RD: begin
                    state_reg <= B_CHK;
                end
                B_CHK: begin
                    state_reg <= B_RD;
                    idx_reg   <= idx_adv;
                    cnt_reg   <= cnt_inc;
                    if (job_reg.is_insert) begin
                        if (!ram_rdata.valid) begin
                            entries_reg  <= entries_reg + CNT_W'(1);
                            m_valid_reg  <= 1'b1;
                            status_reg   <= ST_STORED;
                            slot_reg     <= SLOT_W'(idx_reg);
                            position_reg <= '0;
                            hit_key_reg  <= '0;
                            payload_reg  <= '0;
                            state_reg    <= B_IDLE;
                        end else if (cnt_inc == size) begin
                            m_valid_reg  <= 1'b1;
                            status_reg   <= ST_REFUSED;
                            slot_reg     <= '0;
                            position_reg <= '0;
                            hit_key_reg  <= '0;
                            payload_reg  <= '0;
                            state_reg    <= B_IDLE;
                        end
                    end else begin
                        if (!ram_rdata.valid) begin
                            state_reg <= B_IDLE;
                        end else if (ram_rdata.key == job_reg.key) begin
                            m_valid_reg  <= 1'b1;
                            status_reg   <= ST_HIT;
                            slot_reg     <= SLOT_W'(idx_reg);
                            position_reg <= job_reg.position;
                            hit_key_reg  <= job_reg.key;
                            payload_reg  <= ram_rdata.payload;
                            state_reg    <= B_IDLE;
                        end else if (cnt_inc == size) begin
                            state_reg <= B_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: test/kmer_hash_scan_core_test.sv
// ----------------------------------------------------------------------------
// kmer_hash_scan_core_test
// Self-checking bench for the k-mer hash scan core. A scoreboard keeps its
// own copy of the slot table and the rolling window, predicts the result of
// each accepted item and checks every result item field by field. Stimulus is
// a directed opening followed by random inserts and symbol sequences that
// embed stored k-mers, run over several table sizes with random idling on
// both channels.
// ----------------------------------------------------------------------------
module kmer_hash_scan_core_test;
    import khs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT  = 1500000;
    localparam int  SETTLE       = 400;
    localparam int  POOL_N       = 32;
    localparam int  PAY_W        = $bits(khs_payload_t);
    localparam longint KEY_SPAN  = 64'd25600000000;

    typedef struct {
        logic [1:0]       command;
        logic [SYM_W-1:0] symbol;
        logic [KEY_W-1:0] key;
        khs_payload_t     payload;
    } scan_item_t;

    typedef struct {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  position;
        logic [KEY_W-1:0]  hit_key;
        khs_payload_t      payload;
    } scan_result_t;

    // Table predictor and store of expected result items.
    class kmer_table_scoreboard;
        bit               used[TABLE_DEPTH];
        logic [KEY_W-1:0] stored_key[TABLE_DEPTH];
        khs_payload_t     stored_pay[TABLE_DEPTH];
        longint           size_reg;
        longint           entries;
        longint           window;
        int               run_len;
        longint           next_pos;
        scan_result_t     pending[$];
        int               errors;

        function new();
            size_reg = TABLE_DEPTH;
            entries  = 0;
            window   = 0;
            run_len  = 0;
            next_pos = 0;
            errors   = 0;
            foreach (used[i]) used[i] = 1'b0;
        endfunction

        function void set_size(logic [CFG_W-1:0] value);
            size_reg = value;
        endfunction

        function longint live_size();
            if (size_reg < 2) return 2;
            if (size_reg > TABLE_DEPTH) return TABLE_DEPTH;
            return size_reg;
        endfunction

        // Work out the result of one accepted item and queue it if any.
        function void note_item(scan_item_t it);
            scan_result_t r;
            longint sz, idx, cur;
            r = '{default: '0};
            sz = live_size();
            case (it.command)
                CMD_INSERT: begin
                    r.status = ST_REFUSED;
                    if (entries + 1 < sz / 2) begin
                        idx = longint'(it.key) % sz;
                        for (longint n = 0; n < sz; n++) begin
                            if (!used[idx]) begin
                                used[idx]       = 1'b1;
                                stored_key[idx] = it.key;
                                stored_pay[idx] = it.payload;
                                entries++;
                                r.status = ST_STORED;
                                r.slot   = SLOT_W'(idx);
                                break;
                            end
                            idx = (idx + 1) % sz;
                        end
                    end
                    pending = {pending, r};
                end
                CMD_SYMBOL: begin
                    cur = next_pos;
                    if (next_pos < POS_MAX) next_pos++;
                    if (it.symbol >= SYM_AMBIG) begin
                        window  = 0;
                        run_len = 0;
                    end else begin
                        window = (window % longint'(TOP_WEIGHT)) * 20 + it.symbol;
                        if (run_len < KMER_LEN) run_len++;
                        if (run_len == KMER_LEN) begin
                            idx = window % sz;
                            for (longint n = 0; n < sz; n++) begin
                                if (!used[idx]) break;
                                if (longint'(stored_key[idx]) == window) begin
                                    r.status   = ST_HIT;
                                    r.slot     = SLOT_W'(idx);
                                    r.position = (cur >= POS_MAX) ? POS_MAX
                                                 : POS_W'(cur - (KMER_LEN - 1));
                                    r.hit_key  = KEY_W'(window);
                                    r.payload  = stored_pay[idx];
                                    pending = {pending, r};
                                    break;
                                end
                                idx = (idx + 1) % sz;
                            end
                        end
                    end
                end
                CMD_NEWSEQ: begin
                    window   = 0;
                    run_len  = 0;
                    next_pos = 0;
                end
                default: ;
            endcase
        endfunction

        function void cmp(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Compare one result item with the oldest expectation.
        function void check_result(scan_result_t got);
            scan_result_t e;
            if (pending.size() == 0) begin
                $error("unexpected result item: status %0d slot %0h", got.status, got.slot);
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("status", e.status, got.status);
            cmp("slot", e.slot, got.slot);
            cmp("position", e.position, got.position);
            cmp("hit_key", e.hit_key, got.hit_key);
            cmp("hit_end_offset", e.payload.end_offset, got.payload.end_offset);
            cmp("hit_function", e.payload.function_id, got.payload.function_id);
            cmp("hit_group", e.payload.group_id, got.payload.group_id);
            cmp("hit_weight", e.payload.weight, got.payload.weight);
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_command;
    logic [SYM_W-1:0]  s_symbol;
    logic [KEY_W-1:0]  s_key;
    logic [15:0]       s_end_offset;
    logic [19:0]       s_function_id;
    logic [19:0]       s_group_id;
    logic [15:0]       s_weight;
    logic              m_valid;
    logic              m_ready;
    logic [1:0]        m_status;
    logic [SLOT_W-1:0] m_slot;
    logic [POS_W-1:0]  m_position;
    logic [KEY_W-1:0]  m_hit_key;
    logic [15:0]       m_hit_end_offset;
    logic [19:0]       m_hit_function;
    logic [19:0]       m_hit_group;
    logic [15:0]       m_hit_weight;

    kmer_table_scoreboard sb;
    logic [SYM_W-1:0] kmer_pool[POOL_N][KMER_LEN];
    logic [KEY_W-1:0] pool_key[POOL_N];
    int               burst_left;
    int               sent;
    longint           cycles;
    bit               run_done;

    kmer_hash_scan_core u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_symbol        (s_symbol),
        .s_key           (s_key),
        .s_end_offset    (s_end_offset),
        .s_function_id   (s_function_id),
        .s_group_id      (s_group_id),
        .s_weight        (s_weight),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_slot          (m_slot),
        .m_position      (m_position),
        .m_hit_key       (m_hit_key),
        .m_hit_end_offset(m_hit_end_offset),
        .m_hit_function  (m_hit_function),
        .m_hit_group     (m_hit_group),
        .m_hit_weight    (m_hit_weight)
    );

    // Clock, 8 ns period.
    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // Cycle counter with a hard limit on the run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT && !run_done) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result receiver: the stall pattern switches at random among four modes.
    initial begin
        int mode;
        m_ready = 1'b0;
        mode = 0;
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: m_ready = 1'b1;
                1: m_ready = $urandom_range(0, 1);
                2: m_ready = ($urandom_range(0, 3) == 0);
                default: m_ready = ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        scan_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.status   = m_status;
            got.slot     = m_slot;
            got.position = m_position;
            got.hit_key  = m_hit_key;
            got.payload  = '{m_hit_end_offset, m_hit_function, m_hit_group, m_hit_weight};
            sb.check_result(got);
        end
    end

    // Send one item, then possibly end the burst with a random gap.
    task automatic push_item(scan_item_t it);
        @(negedge aclk);
        s_valid       = 1'b1;
        s_command     = it.command;
        s_symbol      = it.symbol;
        s_key         = it.key;
        s_end_offset  = it.payload.end_offset;
        s_function_id = it.payload.function_id;
        s_group_id    = it.payload.group_id;
        s_weight      = it.payload.weight;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
        sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge aclk);
            burst_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
    endtask

    task automatic push_symbol(int sym);
        scan_item_t it;
        it = '{default: '0};
        it.command = CMD_SYMBOL;
        it.symbol  = SYM_W'(sym);
        push_item(it);
    endtask

    task automatic push_command(logic [1:0] cmd);
        scan_item_t it;
        it.command = cmd;
        it.symbol  = SYM_W'($urandom);
        it.key     = KEY_W'({$urandom, $urandom});
        it.payload = PAY_W'({$urandom, $urandom, $urandom});
        push_item(it);
    endtask

    task automatic push_insert(logic [KEY_W-1:0] k, khs_payload_t p);
        scan_item_t it;
        it = '{default: '0};
        it.command = CMD_INSERT;
        it.key     = k;
        it.payload = p;
        push_item(it);
    endtask

    task automatic push_kmer(int n);
        for (int i = 0; i < KMER_LEN; i++) push_symbol(kmer_pool[n][i]);
    endtask

    // Wait until every expected result has come and the core has settled.
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_size(logic [CFG_W-1:0] value);
        drain();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_size(value);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Random traffic: inserts of pooled k-mers and sequences that embed them.
    task automatic run_phase(int count);
        int stop_at;
        int pick;
        khs_payload_t p;
        stop_at = sent + count;
        while (sent < stop_at) begin
            pick = $urandom_range(0, 99);
            p = PAY_W'({$urandom, $urandom, $urandom});
            if (pick < 14) begin
                push_insert(pool_key[$urandom_range(0, POOL_N - 1)], p);
            end else if (pick < 17) begin
                push_insert(KEY_W'({$urandom, $urandom}), p);
            end else if (pick < 85) begin
                repeat ($urandom_range(0, 3)) push_symbol($urandom_range(0, 19));
                push_kmer($urandom_range(0, POOL_N - 1));
            end else if (pick < 92) begin
                push_symbol($urandom_range(0, 31));
            end else if (pick < 97) begin
                push_command(CMD_NEWSEQ);
            end else begin
                push_command(2'd3);
            end
        end
    endtask

    initial begin
        logic [CFG_W-1:0] sizes[9];
        sb         = new();
        cycles     = 0;
        run_done   = 1'b0;
        sent       = 0;
        burst_left = 0;
        aresetn    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        s_valid    = 1'b0;
        s_command  = CMD_SYMBOL;
        s_symbol   = '0;
        s_key      = '0;
        s_end_offset  = '0;
        s_function_id = '0;
        s_group_id    = '0;
        s_weight      = '0;

        // Pool of k-mers; the first is all zero and the second all nineteen.
        for (int n = 0; n < POOL_N; n++) begin
            longint k;
            k = 0;
            for (int i = 0; i < KMER_LEN; i++) begin
                kmer_pool[n][i] = (n == 0) ? 5'd0 : (n == 1) ? 5'd19
                                  : SYM_W'($urandom_range(0, 19));
                k = k * 20 + kmer_pool[n][i];
            end
            pool_key[n] = KEY_W'(k);
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed opening at the reset table size.
        push_insert(pool_key[0], '0);
        push_insert(pool_key[1], '1);
        push_insert({KEY_W{1'b1}}, {16'h8000, 20'h80000, 20'h00001, 16'h0100});
        push_insert(KEY_W'(KEY_SPAN), PAY_W'({$urandom, $urandom, $urandom}));
        push_kmer(0);
        push_symbol(19);
        push_symbol(20);
        push_kmer(1);
        push_symbol(31);
        push_command(2'd3);
        push_command(CMD_NEWSEQ);
        push_kmer(1);

        // Table sizes from the clamped minimum to beyond the depth.
        sizes = '{17'd0, 17'd16, 17'd100, 17'd3, 17'd131071, 17'd65535,
                  17'd1, 17'd65536, 17'd1000};
        foreach (sizes[i]) begin
            write_size(sizes[i]);
            run_phase((sizes[i] > 200 || sizes[i] == 0) ? 240 : 160);
        end

        // Wind down and report.
        drain();
        run_done = 1'b1;
        if (sb.pending.size() != 0) begin
            $error("%0d expected result items never arrived", sb.pending.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
